>>> hw/rtl/ptdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdt_pkg
// Shared types and constants for the Peltier thermostat with dead time.
// ----------------------------------------------------------------------------
package ptdt_pkg;

  localparam int TempW    = 12;
  localparam int OffsetW  = 8;
  localparam int DeadW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  // Compare width: temperature plus or minus an 8-bit offset never overflows
  localparam int CmpW     = TempW + 2;

  localparam logic signed [TempW-1:0] MIN_VALID_TEMP_DEF = -12'sd200;
  localparam logic signed [TempW-1:0] MAX_VALID_TEMP_DEF = 12'sd1000;

  typedef enum logic [1:0] {
    DirOff  = 2'd0,
    DirCool = 2'd1,
    DirHeat = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetTemp  = 3'd0,
    CfgCoolSwitch  = 3'd1,
    CfgCoolBand    = 3'd2,
    CfgHeatSwitch  = 3'd3,
    CfgHeatBand    = 3'd4,
    CfgDeadTime    = 3'd5,
    CfgDispNear    = 3'd6,
    CfgDispFar     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TempW-1:0] target_temp;
    logic [OffsetW-1:0]      cool_switch_offset;
    logic [OffsetW-1:0]      cool_band_offset;
    logic [OffsetW-1:0]      heat_switch_offset;
    logic [OffsetW-1:0]      heat_band_offset;
    logic [DeadW-1:0]        dead_time_samples;
    logic [OffsetW-1:0]      display_near_offset;
    logic [OffsetW-1:0]      display_far_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic                    sensor_ok;
  } in_t;

  typedef struct packed {
    logic [1:0] drive_direction;
    logic       power_on;
    logic       mode_heat;
    logic       sensor_error;
    logic       show_temperature;
    logic       target_reached;
  } out_t;

endpackage

>>> hw/rtl/ptdt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdt_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module ptdt_cfg
  import ptdt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTargetTemp: cfg_d.target_temp         = $signed(cfg_wdata_i[TempW-1:0]);
        CfgCoolSwitch: cfg_d.cool_switch_offset  = cfg_wdata_i[OffsetW-1:0];
        CfgCoolBand:   cfg_d.cool_band_offset    = cfg_wdata_i[OffsetW-1:0];
        CfgHeatSwitch: cfg_d.heat_switch_offset  = cfg_wdata_i[OffsetW-1:0];
        CfgHeatBand:   cfg_d.heat_band_offset    = cfg_wdata_i[OffsetW-1:0];
        CfgDeadTime:   cfg_d.dead_time_samples   = cfg_wdata_i[DeadW-1:0];
        CfgDispNear:   cfg_d.display_near_offset = cfg_wdata_i[OffsetW-1:0];
        CfgDispFar:    cfg_d.display_far_offset  = cfg_wdata_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp         <= 12'sd370;
      cfg_q.cool_switch_offset  <= 8'd5;
      cfg_q.cool_band_offset    <= 8'd2;
      cfg_q.heat_switch_offset  <= 8'd5;
      cfg_q.heat_band_offset    <= 8'd2;
      cfg_q.dead_time_samples   <= 16'd10;
      cfg_q.display_near_offset <= 8'd2;
      cfg_q.display_far_offset  <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/ptdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdt_ctrl
// Control state and per-sample decision logic: mode pick, band hysteresis,
// dead-time switch-over, sensor check and display hysteresis.
// ----------------------------------------------------------------------------
module ptdt_ctrl
  import ptdt_pkg::*;
#(
  parameter logic signed [TempW-1:0] MIN_VALID_TEMP = MIN_VALID_TEMP_DEF,
  parameter logic signed [TempW-1:0] MAX_VALID_TEMP = MAX_VALID_TEMP_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic step_i,
  input  in_t  sample_i,
  output out_t res_o
);

  logic             started_q, started_d;
  logic             heat_mode_q, heat_mode_d;
  logic             dead_run_q, dead_run_d;
  logic [DeadW-1:0] dead_cnt_q, dead_cnt_d;
  dir_e             pins_q, pins_d;
  logic             power_q, power_d;
  logic             achieved_q, achieved_d;

  logic signed [CmpW-1:0] t_w, tgt_w;
  logic signed [CmpW-1:0] cool_sw_th, cool_band_th, heat_sw_th, heat_band_th;
  logic signed [CmpW-1:0] near_hi, near_lo, far_hi, far_lo;
  logic                   sample_ok, err, show, to_heat, beyond_switch;
  logic [DeadW-1:0]       cnt_adv;

  function automatic logic signed [CmpW-1:0] ext_off(input logic [OffsetW-1:0] off);
    return $signed({{(CmpW-OffsetW){1'b0}}, off});
  endfunction

  always_comb begin
    t_w   = CmpW'(sample_i.temperature);
    tgt_w = CmpW'(cfg_i.target_temp);

    cool_sw_th   = tgt_w - ext_off(cfg_i.cool_switch_offset);
    cool_band_th = tgt_w + ext_off(cfg_i.cool_band_offset);
    heat_sw_th   = tgt_w + ext_off(cfg_i.heat_switch_offset);
    heat_band_th = tgt_w - ext_off(cfg_i.heat_band_offset);
    near_hi      = tgt_w + ext_off(cfg_i.display_near_offset);
    near_lo      = tgt_w - ext_off(cfg_i.display_near_offset);
    far_hi       = tgt_w + ext_off(cfg_i.display_far_offset);
    far_lo       = tgt_w - ext_off(cfg_i.display_far_offset);

    sample_ok = sample_i.sensor_ok &&
                (sample_i.temperature > MIN_VALID_TEMP) &&
                (sample_i.temperature < MAX_VALID_TEMP);

    // advance the dead-time count first, saturating
    cnt_adv = (dead_run_q && (dead_cnt_q != {DeadW{1'b1}})) ?
              dead_cnt_q + DeadW'(1) : dead_cnt_q;

    started_d   = started_q;
    heat_mode_d = heat_mode_q;
    dead_run_d  = dead_run_q;
    dead_cnt_d  = cnt_adv;
    pins_d      = pins_q;
    power_d     = power_q;
    err         = 1'b0;
    to_heat     = !heat_mode_q;
    beyond_switch = 1'b0;

    if (!sample_ok) begin
      err     = 1'b1;
      pins_d  = DirOff;
      power_d = 1'b0;
    end else if (!started_q) begin
      started_d   = 1'b1;
      heat_mode_d = !(tgt_w <= t_w);
      pins_d      = DirOff;
      power_d     = 1'b0;
    end else if (!heat_mode_q) begin
      if (t_w <= cool_sw_th) begin
        beyond_switch = 1'b1;
      end else if (t_w <= cool_band_th) begin
        power_d = 1'b0;
      end else begin
        pins_d  = DirCool;
        power_d = 1'b1;
      end
    end else begin
      if (t_w >= heat_sw_th) begin
        beyond_switch = 1'b1;
      end else if (t_w >= heat_band_th) begin
        power_d = 1'b0;
      end else begin
        pins_d  = DirHeat;
        power_d = 1'b1;
      end
    end

    // past the switch threshold: cut drive, start or finish the dead time
    if (beyond_switch) begin
      pins_d  = DirOff;
      power_d = 1'b0;
      if (dead_run_q) begin
        if (cnt_adv >= cfg_i.dead_time_samples) begin
          heat_mode_d = to_heat;
          dead_run_d  = 1'b0;
        end
      end else begin
        dead_run_d = 1'b1;
        dead_cnt_d = '0;
      end
    end

    achieved_d = achieved_q;
    if ((t_w <= near_hi) && (t_w >= near_lo)) begin
      achieved_d = 1'b1;
      show       = 1'b1;
    end else if ((t_w > far_hi) || (t_w < far_lo)) begin
      achieved_d = 1'b0;
      show       = 1'b1;
    end else begin
      show = !achieved_q;
    end

    res_o.drive_direction  = pins_d;
    res_o.power_on         = power_d;
    res_o.mode_heat        = heat_mode_d;
    res_o.sensor_error     = err;
    res_o.show_temperature = show;
    res_o.target_reached   = achieved_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      heat_mode_q <= 1'b0;
      dead_run_q  <= 1'b0;
      dead_cnt_q  <= '0;
      pins_q      <= DirOff;
      power_q     <= 1'b0;
      achieved_q  <= 1'b0;
    end else if (step_i) begin
      started_q   <= started_d;
      heat_mode_q <= heat_mode_d;
      dead_run_q  <= dead_run_d;
      dead_cnt_q  <= dead_cnt_d;
      pins_q      <= pins_d;
      power_q     <= power_d;
      achieved_q  <= achieved_d;
    end
  end

`ifndef ASSERT_OFF
  // power is only ever enabled together with a bridge direction
  a_power_has_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_q |-> (pins_q != DirOff))
    else $error("power on with bridge off");

  // nothing is driven before the first valid sample picks a mode
  a_idle_until_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> ((pins_q == DirOff) && !power_q && !dead_run_q))
    else $error("drive active before start");

  // a bad sample leaves all drive off
  a_err_cuts_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !sample_ok) |=> ((pins_q == DirOff) && !power_q))
    else $error("drive left on after sensor error");

  // the dead time ends only by flipping the mode
  a_dead_end_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && dead_run_q && !dead_run_d) |-> (heat_mode_d != heat_mode_q))
    else $error("dead time ended without mode flip");
`endif

endmodule

>>> hw/rtl/peltier_thermostat_with_dead_time_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peltier_thermostat_with_dead_time_unit
// Bang-bang Peltier thermostat with band hysteresis, dead-time mode switch
// and a display band flag; one result per temperature sample.
// ----------------------------------------------------------------------------
//  Channel   Signals                                Direction
//  -------   ------------------------------------   ---------
//  sample    in_valid_i / in_ready_o / in_data_i    in
//  result    out_valid_o / out_ready_i / out_data_o out
//  config    cfg_we_i / cfg_idx_i / cfg_wdata_i     in, write only
//
//  A sample enters the input register, is judged against the control state
//  combinationally and lands in the result register; while the result side
//  accepts, one sample per cycle is sustained. The state update happens on the
//  transfer from input to result register, so a stalled result holds the input
//  register and backpressure reaches in_ready_o in the same cycle. Reset clears
//  all control state and loads the register defaults.
// ----------------------------------------------------------------------------
module peltier_thermostat_with_dead_time_unit
  import ptdt_pkg::*;
#(
  parameter logic signed [TempW-1:0] MIN_VALID_TEMP = MIN_VALID_TEMP_DEF,
  parameter logic signed [TempW-1:0] MAX_VALID_TEMP = MAX_VALID_TEMP_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;
  out_t res;

  logic in_vld_q, in_vld_d;
  in_t  in_data_q;
  logic out_vld_q, out_vld_d;
  out_t out_data_q;
  logic step;

  ptdt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ptdt_ctrl #(
    .MIN_VALID_TEMP (MIN_VALID_TEMP),
    .MAX_VALID_TEMP (MAX_VALID_TEMP)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .sample_i (in_data_q),
    .res_o    (res)
  );

  // advance when the result register is free or being drained
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

>>> tb/ptdt_thermostat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptdt_thermostat_checker
// Watches the sample, result and register ports of the Peltier thermostat,
// keeps its own copy of the control state and register settings, predicts
// the result of every accepted sample and compares it field by field.
// ----------------------------------------------------------------------------
module ptdt_thermostat_checker
  import ptdt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_t                out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  cfg_t             setpoints;
  logic             started;
  logic             heat_mode;
  logic             dead_running;
  logic [DeadW-1:0] dead_count;
  dir_e             drive_dir;
  logic             power;
  logic             achieved;
  out_t             thermo_result_q[$];
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] thermostat checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
    end
  endtask

  function automatic void apply_setting(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    case (idx)
      CfgTargetTemp: setpoints.target_temp         = d[TempW-1:0];
      CfgCoolSwitch: setpoints.cool_switch_offset  = d[OffsetW-1:0];
      CfgCoolBand:   setpoints.cool_band_offset    = d[OffsetW-1:0];
      CfgHeatSwitch: setpoints.heat_switch_offset  = d[OffsetW-1:0];
      CfgHeatBand:   setpoints.heat_band_offset    = d[OffsetW-1:0];
      CfgDeadTime:   setpoints.dead_time_samples   = d[DeadW-1:0];
      CfgDispNear:   setpoints.display_near_offset = d[OffsetW-1:0];
      CfgDispFar:    setpoints.display_far_offset  = d[OffsetW-1:0];
      default: ;
    endcase
  endfunction

  // Beyond the switch threshold: cut drive, then start, run or finish the dead time.
  function automatic void enter_dead_time(input logic to_heat);
    drive_dir = DirOff;
    power     = 1'b0;
    if (dead_running) begin
      if (dead_count >= setpoints.dead_time_samples) begin
        heat_mode    = to_heat;
        dead_running = 1'b0;
      end
    end else begin
      dead_running = 1'b1;
      dead_count   = '0;
    end
  endfunction

  function automatic out_t judge_sample(input in_t s);
    int   t;
    int   tgt;
    int   near_band;
    int   far_band;
    logic fault;
    logic show;
    out_t r;
    t         = $signed(s.temperature);
    tgt       = $signed(setpoints.target_temp);
    near_band = int'(setpoints.display_near_offset);
    far_band  = int'(setpoints.display_far_offset);
    fault     = 1'b0;

    if (dead_running && dead_count != '1) dead_count++;

    if (!s.sensor_ok || t <= MIN_VALID_TEMP_DEF || t >= MAX_VALID_TEMP_DEF) begin
      fault     = 1'b1;
      drive_dir = DirOff;
      power     = 1'b0;
    end else if (!started) begin
      started   = 1'b1;
      heat_mode = (t < tgt);
      drive_dir = DirOff;
      power     = 1'b0;
    end else if (!heat_mode) begin
      if (t <= tgt - int'(setpoints.cool_switch_offset)) begin
        enter_dead_time(1'b1);
      end else if (t <= tgt + int'(setpoints.cool_band_offset)) begin
        power = 1'b0;
      end else begin
        drive_dir = DirCool;
        power     = 1'b1;
      end
    end else begin
      if (t >= tgt + int'(setpoints.heat_switch_offset)) begin
        enter_dead_time(1'b0);
      end else if (t >= tgt - int'(setpoints.heat_band_offset)) begin
        power = 1'b0;
      end else begin
        drive_dir = DirHeat;
        power     = 1'b1;
      end
    end

    // Near band wins over the far band when the far band is the narrower one.
    if (t <= tgt + near_band && t >= tgt - near_band) begin
      achieved = 1'b1;
      show     = 1'b1;
    end else if (t > tgt + far_band || t < tgt - far_band) begin
      achieved = 1'b0;
      show     = 1'b1;
    end else begin
      show = !achieved;
    end

    r.drive_direction  = drive_dir;
    r.power_on         = power;
    r.mode_heat        = heat_mode;
    r.sensor_error     = fault;
    r.show_temperature = show;
    r.target_reached   = achieved;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      setpoints = '{target_temp: 370, cool_switch_offset: 5, cool_band_offset: 2,
                    heat_switch_offset: 5, heat_band_offset: 2, dead_time_samples: 10,
                    display_near_offset: 2, display_far_offset: 5};
      started      = 1'b0;
      heat_mode    = 1'b0;
      dead_running = 1'b0;
      dead_count   = '0;
      drive_dir    = DirOff;
      power        = 1'b0;
      achieved     = 1'b0;
      thermo_result_q.delete();
    end else begin
      if (cfg_we_i) apply_setting(cfg_idx_e'(cfg_idx_i), cfg_wdata_i);
      // Retire the result before queuing a new sample from the same edge.
      if (out_valid_i && out_ready_i) begin
        if (thermo_result_q.size() == 0) begin
          report_mismatch("result transfer with no sample outstanding");
        end else begin
          want = thermo_result_q.pop_front();
          check_field("drive_direction", out_data_i.drive_direction, want.drive_direction);
          check_field("power_on", out_data_i.power_on, want.power_on);
          check_field("mode_heat", out_data_i.mode_heat, want.mode_heat);
          check_field("sensor_error", out_data_i.sensor_error, want.sensor_error);
          check_field("show_temperature", out_data_i.show_temperature,
                      want.show_temperature);
          check_field("target_reached", out_data_i.target_reached, want.target_reached);
        end
      end
      if (in_valid_i && in_ready_i) thermo_result_q.push_back(judge_sample(in_data_i));
    end
    pending_o = thermo_result_q.size();
  end

endmodule

>>> tb/peltier_thermostat_with_dead_time_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peltier_thermostat_with_dead_time_unit_tb
// Drives temperature samples and register settings into the thermostat under
// varied handshake traffic; a checker beside the block predicts and compares
// every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module peltier_thermostat_with_dead_time_unit_tb;
  import ptdt_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int QuietLimit   = 5000;
  localparam int RandomPhases = 8;
  localparam int PhaseSamples = 130;
  localparam int InW          = $bits(in_t);

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int   fail_count;
  int   pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_results   = 1'b0;
  int   n_samples      = 0;
  int   n_results      = 0;
  int   n_settings     = 1;
  in_t  sample_q[$];

  peltier_thermostat_with_dead_time_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ptdt_thermostat_checker thermo_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer the next queued sample once the previous one has transferred.
  initial begin : sample_source
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_data  <= InW'($urandom);
        end
      end
    end
  end

  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      quiet++;
      if (in_valid && in_ready) begin
        n_samples++;
        quiet = 0;
      end
      if (out_valid && out_ready) begin
        n_results++;
        quiet = 0;
      end
    end
    $display("peltier_thermostat_with_dead_time_unit_tb: no transfer for %0d cycles",
             QuietLimit);
    $display("peltier_thermostat_with_dead_time_unit_tb: FAIL");
    $finish;
  end

  task automatic push_sample(input int t, input bit ok);
    in_t s;
    s.temperature = t[TempW-1:0];
    s.sensor_ok   = ok;
    sample_q.push_back(s);
  endtask

  task automatic set_traffic(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Hold until every queued sample has transferred and every result is back.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
  endtask

  // Upper data bits are random: the block must drop them for narrow registers.
  task automatic load_setpoints(input cfg_t c);
    write_reg(CfgTargetTemp, {4'($urandom), c.target_temp});
    write_reg(CfgCoolSwitch, {8'($urandom), c.cool_switch_offset});
    write_reg(CfgCoolBand,   {8'($urandom), c.cool_band_offset});
    write_reg(CfgHeatSwitch, {8'($urandom), c.heat_switch_offset});
    write_reg(CfgHeatBand,   {8'($urandom), c.heat_band_offset});
    write_reg(CfgDeadTime,   c.dead_time_samples);
    write_reg(CfgDispNear,   {8'($urandom), c.display_near_offset});
    write_reg(CfgDispFar,    {8'($urandom), c.display_far_offset});
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [OffsetW-1:0] pick_offset();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return OffsetW'($urandom_range(12));
    endcase
  endfunction

  function automatic cfg_t random_setpoints();
    cfg_t c;
    case ($urandom_range(7))
      0: c.target_temp = 12'h800;
      1: c.target_temp = 12'h7FF;
      default: c.target_temp = 12'(int'($urandom_range(1000)) - 150);
    endcase
    c.cool_switch_offset  = pick_offset();
    c.cool_band_offset    = pick_offset();
    c.heat_switch_offset  = pick_offset();
    c.heat_band_offset    = pick_offset();
    c.display_near_offset = pick_offset();
    c.display_far_offset  = pick_offset();
    case ($urandom_range(15))
      0, 1: c.dead_time_samples = '0;
      2: c.dead_time_samples = '1;
      default: c.dead_time_samples = 16'($urandom_range(6));
    endcase
    return c;
  endfunction

  // Sweep the temperature back and forth across both switch thresholds, with
  // dwells, sensor faults, out-of-range readings and raw noise mixed in.
  task automatic run_walk(input cfg_t c, input int n, input bit pause_mid);
    int tgt;
    int amp;
    int pos;
    int dir;
    int roll;
    tgt = $signed(c.target_temp);
    amp = int'(c.cool_switch_offset > c.heat_switch_offset ?
               c.cool_switch_offset : c.heat_switch_offset) + $urandom_range(3, 12);
    pos = tgt;
    dir = 1;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_idle();
      roll = $urandom_range(99);
      if (roll < 6) begin
        push_sample($urandom_range(4095), 1'b0);
      end else if (roll < 10) begin
        push_sample($urandom_range(1) ? -200 - int'($urandom_range(1848))
                                      : 1000 + int'($urandom_range(1047)), 1'b1);
      end else if (roll < 13) begin
        push_sample($urandom_range(4095), $urandom_range(1) == 1);
      end else begin
        if (roll >= 20) pos += dir * int'($urandom_range(1, 1 + amp / 16));
        if (pos > tgt + amp) dir = -1;
        if (pos < tgt - amp) dir = 1;
        if (pos >= 999) begin
          pos = 999;
          dir = -1;
        end
        if (pos <= -199) begin
          pos = -199;
          dir = 1;
        end
        push_sample(pos, 1'b1);
      end
    end
  endtask

  initial begin : stimulus
    cfg_t c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a fault before start, range limits, heat picked first.
    set_traffic(0, 0);
    push_sample(370, 1'b0);
    push_sample(-200, 1'b1);
    push_sample(1000, 1'b1);
    push_sample(-2048, 1'b1);
    push_sample(2047, 1'b1);
    push_sample(-199, 1'b1);
    push_sample(999, 1'b1);
    push_sample(367, 1'b1);
    push_sample(368, 1'b1);
    push_sample(372, 1'b1);
    push_sample(373, 1'b1);
    push_sample(376, 1'b1);
    push_sample(375, 1'b0);
    wait_idle();

    // All zero: zero dead time, so the mode flips on the first sample past a threshold after the one that starts it.
    set_traffic(77, 0);
    c = '0;
    load_setpoints(c);
    push_sample(0, 1'b1);
    push_sample(0, 1'b1);
    push_sample(0, 1'b1);
    push_sample(-1, 1'b1);
    push_sample(1, 1'b1);
    push_sample(-1, 1'b1);
    push_sample(2, 1'b1);
    push_sample(3, 1'b1);
    wait_idle();

    // Widest offsets, longest dead time, far band narrower than near band.
    set_traffic(0, 77);
    c = '{target_temp: 12'h800, cool_switch_offset: 255, cool_band_offset: 255,
          heat_switch_offset: 255, heat_band_offset: 255, dead_time_samples: 16'hFFFF,
          display_near_offset: 255, display_far_offset: 0};
    load_setpoints(c);
    push_sample(-150, 1'b1);
    push_sample(999, 1'b1);
    push_sample(-199, 1'b0);
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p % 4)
        0: set_traffic(0, 0);
        1: set_traffic(77, 0);
        2: set_traffic(0, 77);
        default: set_traffic(9, 9);
      endcase
      // Stall the result side long enough for the block to back up its input.
      if (p == 0) hold_results = 1'b1;
      c = random_setpoints();
      if (p == RandomPhases - 1) c.target_temp = 12'h7FF;
      load_setpoints(c);
      run_walk(c, PhaseSamples, p == 3);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    $display("peltier_thermostat_with_dead_time_unit_tb: %0d samples, %0d results, %0d settings",
             n_samples, n_results, n_settings);
    $display("peltier_thermostat_with_dead_time_unit_tb: full rate, sparse input, slow output,");
    $display("  light two-sided idling and one long output hold with input backpressure");
    if (pending != 0) begin
      $display("peltier_thermostat_with_dead_time_unit_tb: %0d results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("peltier_thermostat_with_dead_time_unit_tb: PASS");
    end else begin
      $display("peltier_thermostat_with_dead_time_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
